>>> rtl/sliding_window_percentile_top_assert.svh
// ----------------------------------------------------------------------------
// Sliding window percentile - assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_PERCENTILE_TOP_ASSERT_SVH
`define SLIDING_WINDOW_PERCENTILE_TOP_ASSERT_SVH

// same-cycle implication
`define SWP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sliding window percentile: assertion failed");

// next-cycle implication
`define SWP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sliding window percentile: assertion failed");

`endif

>>> rtl/swp_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window percentile - package
// Field widths, register indexes and inter-module control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package swp_pkg;

    localparam int TIME_W      = 24;
    localparam int FRAC_W      = 17;
    localparam int COUNT_W     = 8;
    localparam int FRAC_SHIFT  = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 56;

    localparam logic [CFG_INDEX_W-1:0] REG_RANK_FRACTION_A = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RANK_FRACTION_B = 2'd1;

    localparam logic [FRAC_W-1:0] RANK_FRACTION_A_RESET = 17'd64881;
    localparam logic [FRAC_W-1:0] RANK_FRACTION_B_RESET = 17'd65536;

    typedef struct packed {
        logic start;
        logic full;
    } merge_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } merge_stat_t;

endpackage

`default_nettype wire

>>> rtl/swp_ring.sv
// ----------------------------------------------------------------------------
// Sliding window percentile - ring store
// Arrival-order window: writes each sample, returns the evicted one.
// ----------------------------------------------------------------------------
`default_nettype none

module swp_ring #(
    parameter int WINDOW      = 180,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    input  wire logic [SAMPLE_BITS-1:0]         sample,
    output logic      [SAMPLE_BITS-1:0]         old_data,
    output logic      [$clog2(WINDOW+1)-1:0]    count,
    output logic                                full
);
    import swp_pkg::*;

    localparam int IDX_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);

    logic [SAMPLE_BITS-1:0] mem [WINDOW];
    logic [SAMPLE_BITS-1:0] old_reg;
    logic [IDX_W-1:0]       oldest_reg, oldest_next;
    logic [CNT_W-1:0]       fill_reg, fill_next;
    logic [CNT_W:0]         sum;
    logic [CNT_W:0]         wrap;
    logic [IDX_W-1:0]       wr_addr;

    always_comb
    begin
        full    = (fill_reg == CNT_W'(WINDOW));
        sum     = (CNT_W+1)'(oldest_reg) + (CNT_W+1)'(fill_reg);
        wrap    = (sum >= (CNT_W+1)'(WINDOW)) ? sum - (CNT_W+1)'(WINDOW) : sum;
        wr_addr = wrap[IDX_W-1:0];

        oldest_next = oldest_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            if (full)
            begin
                oldest_next = (oldest_reg == IDX_W'(WINDOW - 1)) ? '0 : oldest_reg + 1'b1;
            end
            else
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            oldest_reg <= oldest_next;
            fill_reg   <= fill_next;
        end
    end

    // read-before-write: a full window returns the sample being replaced
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_addr] <= sample;
            old_reg      <= mem[oldest_reg];
        end
    end

    assign old_data = old_reg;
    assign count    = fill_reg;

endmodule

`default_nettype wire

>>> rtl/swp_merge.sv
// ----------------------------------------------------------------------------
// Sliding window percentile - sorted store and merge sweep
// Ascending one-entry-a-cycle sweep that deletes the evicted sample and
// inserts the new one, keeping the store sorted. Idle reads serve ranks.
// ----------------------------------------------------------------------------
`default_nettype none

module swp_merge #(
    parameter int WINDOW      = 180,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire swp_pkg::merge_cmd_t            cmd,
    input  wire logic [SAMPLE_BITS-1:0]         sample,
    input  wire logic [SAMPLE_BITS-1:0]         old_sample,
    input  wire logic [$clog2(WINDOW+1)-1:0]    count,
    input  wire logic [$clog2(WINDOW)-1:0]      rank_addr,
    output logic      [SAMPLE_BITS-1:0]         rd_data,
    output swp_pkg::merge_stat_t                stat
);
    import swp_pkg::*;

    localparam int IDX_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);

    localparam logic [1:0] M_IDLE  = 2'd0;
    localparam logic [1:0] M_FETCH = 2'd1;
    localparam logic [1:0] M_SWEEP = 2'd2;
    localparam logic [1:0] M_FLUSH = 2'd3;

    logic [SAMPLE_BITS-1:0] mem [WINDOW];
    logic [SAMPLE_BITS-1:0] rd_reg;

    logic [1:0]             phase_reg, phase_next;
    logic [SAMPLE_BITS-1:0] x_reg, x_next;
    logic [SAMPLE_BITS-1:0] old_reg, old_next;
    logic [SAMPLE_BITS-1:0] q_reg, q_next;
    logic                   q_valid_reg, q_valid_next;
    logic                   x_pend_reg, x_pend_next;
    logic                   old_pend_reg, old_pend_next;
    logic [CNT_W-1:0]       m_reg, m_next;
    logic [CNT_W-1:0]       proc_reg, proc_next;
    logic [CNT_W-1:0]       w_reg, w_next;
    logic [CNT_W-1:0]       proc_inc;

    logic                   we;
    logic [SAMPLE_BITS-1:0] wd;
    logic [IDX_W-1:0]       ra;
    logic                   del;

    always_comb
    begin
        phase_next    = phase_reg;
        x_next        = x_reg;
        old_next      = old_reg;
        q_next        = q_reg;
        q_valid_next  = q_valid_reg;
        x_pend_next   = x_pend_reg;
        old_pend_next = old_pend_reg;
        m_next        = m_reg;
        proc_next     = proc_reg;
        w_next        = w_reg;
        we            = 1'b0;
        wd            = rd_reg;
        ra            = rank_addr;
        proc_inc      = proc_reg + 1'b1;
        del           = old_pend_reg && (rd_reg == old_reg);

        unique case (phase_reg)
            M_IDLE:
            begin
                if (cmd.start)
                begin
                    x_next        = sample;
                    old_next      = old_sample;
                    m_next        = count;
                    old_pend_next = cmd.full;
                    x_pend_next   = 1'b1;
                    q_valid_next  = 1'b0;
                    proc_next     = '0;
                    w_next        = '0;
                    phase_next    = (count == '0) ? M_FLUSH : M_FETCH;
                end
            end
            M_FETCH:
            begin
                ra         = '0;
                phase_next = M_SWEEP;
            end
            M_SWEEP:
            begin
                ra = (proc_inc < m_reg) ? proc_inc[IDX_W-1:0] : '0;
                priority if (q_valid_reg)
                begin
                    we = 1'b1;
                    wd = q_reg;
                    if (del)
                    begin
                        q_valid_next  = 1'b0;
                        old_pend_next = 1'b0;
                    end
                    else
                    begin
                        q_next = rd_reg;
                    end
                end
                else if (x_pend_reg && (x_reg <= rd_reg))
                begin
                    we          = 1'b1;
                    wd          = x_reg;
                    x_pend_next = 1'b0;
                    if (del)
                    begin
                        old_pend_next = 1'b0;
                    end
                    else
                    begin
                        q_next       = rd_reg;
                        q_valid_next = 1'b1;
                    end
                end
                else if (del)
                begin
                    old_pend_next = 1'b0;
                end
                else
                begin
                    we = 1'b1;
                    wd = rd_reg;
                end
                w_next    = w_reg + CNT_W'(we);
                proc_next = proc_inc;
                if (proc_inc == m_reg)
                begin
                    phase_next = M_FLUSH;
                end
            end
            M_FLUSH:
            begin
                priority if (q_valid_reg)
                begin
                    we = 1'b1;
                    wd = q_reg;
                end
                else if (x_pend_reg)
                begin
                    we = 1'b1;
                    wd = x_reg;
                end
                else
                begin
                    we = 1'b0;
                end
                q_valid_next = 1'b0;
                x_pend_next  = 1'b0;
                phase_next   = M_IDLE;
            end
            default:
            begin
                phase_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= M_IDLE;
            q_valid_reg  <= 1'b0;
            x_pend_reg   <= 1'b0;
            old_pend_reg <= 1'b0;
            proc_reg     <= '0;
            w_reg        <= '0;
            m_reg        <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            q_valid_reg  <= q_valid_next;
            x_pend_reg   <= x_pend_next;
            old_pend_reg <= old_pend_next;
            proc_reg     <= proc_next;
            w_reg        <= w_next;
            m_reg        <= m_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        old_reg <= old_next;
        q_reg   <= q_next;
    end

    // write trails read by at most two slots; same-slot read returns old data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[w_reg[IDX_W-1:0]] <= wd;
        end
        rd_reg <= mem[ra];
    end

    assign rd_data = rd_reg;
    assign stat    = '{busy: (phase_reg != M_IDLE), done: (phase_reg == M_FLUSH)};

endmodule

`default_nettype wire

>>> rtl/swp_rank.sv
// ----------------------------------------------------------------------------
// Sliding window percentile - rank unit
// k = min(n - 1, floor(fraction * n / 2^16)).
// ----------------------------------------------------------------------------
`default_nettype none

module swp_rank #(
    parameter int WINDOW = 180
) (
    input  wire logic [swp_pkg::FRAC_W-1:0]     frac,
    input  wire logic [$clog2(WINDOW+1)-1:0]    n,
    output logic      [$clog2(WINDOW)-1:0]      k
);
    import swp_pkg::*;

    localparam int IDX_W  = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int PROD_W = FRAC_W + CNT_W;

    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] quot;
    logic [PROD_W-1:0] last;
    logic [PROD_W-1:0] kk;

    always_comb
    begin
        prod = PROD_W'(frac) * PROD_W'(n);
        quot = prod >> FRAC_SHIFT;
        last = PROD_W'(n) - 1'b1;
        kk   = (quot > last) ? last : quot;
        k    = kk[IDX_W-1:0];
    end

endmodule

`default_nettype wire

>>> rtl/sliding_window_percentile_top.sv
// ----------------------------------------------------------------------------
// Sliding window percentile - top level
// Window of recent frame times reporting two configurable order statistics.
// ----------------------------------------------------------------------------
// Usage:
//   s_* : one frame_time per beat. s_tready is high only while idle.
//   m_* : one result per input beat, {sample_count, rank_value_b,
//         rank_value_a}. Held in an output register until taken.
//   cfg_*: register writes, always ready. Index 0 rank_fraction_a,
//         index 1 rank_fraction_b (Q16, 65536 = 1.0); other indexes ignored.
// Timing:
//   An item passes from accept through the merge sweep and two rank reads
//   of the sorted store to the output register. The time taken grows with
//   n, the samples held before it (at most WINDOW), and is set by the merge
//   sweep, which walks the sorted store one entry a cycle. A new item is
//   accepted only once the last result has entered the output register.
// Reset:
//   Window empty, fractions at 0.99 and 1.0. No store clearing pass.
// Stall:
//   A stalled result blocks only the next result; the following item is
//   accepted and worked on, then held until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_percentile_top #(
    parameter int WINDOW      = 180,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [swp_pkg::IN_DATA_W-1:0]      s_tdata,   // [23:0] frame_time
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [23:0] rank_value_a, [47:24] rank_value_b, [55:48] sample_count
    output logic      [swp_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [swp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [swp_pkg::FRAC_W-1:0]         cfg_data
);
    import swp_pkg::*;

    localparam int IDX_W   = $clog2(WINDOW);
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int EXT_W   = (SAMPLE_BITS > TIME_W) ? SAMPLE_BITS : TIME_W;
    localparam int CNTX_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    localparam logic [2:0] T_IDLE  = 3'd0;
    localparam logic [2:0] T_RING  = 3'd1;
    localparam logic [2:0] T_MERGE = 3'd2;
    localparam logic [2:0] T_RANKA = 3'd3;
    localparam logic [2:0] T_RANKB = 3'd4;
    localparam logic [2:0] T_CAPB  = 3'd5;
    localparam logic [2:0] T_PUSH  = 3'd6;

    logic [2:0]             state_reg, state_next;
    logic [FRAC_W-1:0]      frac_a_reg, frac_b_reg;
    logic [SAMPLE_BITS-1:0] x_reg;
    logic                   full_reg;
    logic [CNT_W-1:0]       m_reg;
    logic [CNT_W-1:0]       n_reg;
    logic [SAMPLE_BITS-1:0] val_a_reg, val_b_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]  out_data_reg;

    logic                   in_accept;
    logic                   out_load;
    logic [EXT_W-1:0]       in_ext;
    logic [EXT_W-1:0]       sat_max;
    logic [SAMPLE_BITS-1:0] x_sat;
    logic [EXT_W-1:0]       a_ext, b_ext;
    logic [CNTX_W-1:0]      cnt_ext;

    logic [SAMPLE_BITS-1:0] ring_old;
    logic [CNT_W-1:0]       ring_count;
    logic                   ring_full;
    merge_cmd_t             mcmd;
    merge_stat_t            mstat;
    logic [SAMPLE_BITS-1:0] sorted_rd;
    logic [FRAC_W-1:0]      rank_frac;
    logic [IDX_W-1:0]       rank_k;

    assign s_tready  = (state_reg == T_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == T_PUSH) && (!out_valid_reg || m_tready);

    always_comb
    begin
        in_ext  = EXT_W'(s_tdata);
        sat_max = EXT_W'({SAMPLE_BITS{1'b1}});
        x_sat   = (in_ext > sat_max) ? sat_max[SAMPLE_BITS-1:0] : in_ext[SAMPLE_BITS-1:0];
        a_ext   = EXT_W'(val_a_reg);
        b_ext   = EXT_W'(val_b_reg);
        cnt_ext = CNTX_W'(n_reg);
    end

    swp_ring #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (in_accept),
        .sample   (x_sat),
        .old_data (ring_old),
        .count    (ring_count),
        .full     (ring_full)
    );

    assign mcmd = '{start: (state_reg == T_RING), full: full_reg};

    swp_merge #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (mcmd),
        .sample     (x_reg),
        .old_sample (ring_old),
        .count      (m_reg),
        .rank_addr  (rank_k),
        .rd_data    (sorted_rd),
        .stat       (mstat)
    );

    assign rank_frac = (state_reg == T_RANKB) ? frac_b_reg : frac_a_reg;

    swp_rank #(
        .WINDOW (WINDOW)
    ) u_rank (
        .frac (rank_frac),
        .n    (n_reg),
        .k    (rank_k)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE:  state_next = in_accept ? T_RING : T_IDLE;
            T_RING:  state_next = T_MERGE;
            T_MERGE: state_next = mstat.done ? T_RANKA : T_MERGE;
            T_RANKA: state_next = T_RANKB;
            T_RANKB: state_next = T_CAPB;
            T_CAPB:  state_next = T_PUSH;
            T_PUSH:  state_next = out_load ? T_IDLE : T_PUSH;
            default: state_next = T_IDLE;
        endcase

        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            out_valid_reg <= 1'b0;
            frac_a_reg    <= RANK_FRACTION_A_RESET;
            frac_b_reg    <= RANK_FRACTION_B_RESET;
            full_reg      <= 1'b0;
            m_reg         <= '0;
            n_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_RANK_FRACTION_A)
                begin
                    frac_a_reg <= cfg_data;
                end
                if (cfg_index == REG_RANK_FRACTION_B)
                begin
                    frac_b_reg <= cfg_data;
                end
            end
            if (in_accept)
            begin
                full_reg <= ring_full;
                m_reg    <= ring_count;
                n_reg    <= ring_full ? ring_count : ring_count + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            x_reg <= x_sat;
        end
        if (state_reg == T_RANKB)
        begin
            val_a_reg <= sorted_rd;
        end
        if (state_reg == T_CAPB)
        begin
            val_b_reg <= sorted_rd;
        end
        if (out_load)
        begin
            out_data_reg <= {cnt_ext[COUNT_W-1:0], b_ext[TIME_W-1:0], a_ext[TIME_W-1:0]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`include "sliding_window_percentile_top_assert.svh"

    `SWP_ASSERT_NOW(a_ready_merge_idle, s_tready, !mstat.busy)
    `SWP_ASSERT_NEXT(a_accept_starts, in_accept, (state_reg == T_RING) && (n_reg != '0))
    `SWP_ASSERT_NEXT(a_load_shows, out_load, m_tvalid)
    `SWP_ASSERT_NOW(a_merge_only_in_sweep, mstat.busy, (state_reg == T_MERGE))

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// Sliding window percentile - testbench
// Streams frame times through the block and scores every result beat against
// a predictor. The predictor keeps the window as a ring plus a sorted copy.
// A directed pass hits an empty window, field extremes, out-of-range
// and zero fractions, and writes to unused register indexes. Random phases
// follow, each with new fractions, under random sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import swp_pkg::*;

    localparam int WINDOW       = 180;
    localparam int LIMIT_CYCLES = 6_000_000;
    localparam int LONG_HOLD    = 3000;
    localparam int TAIL_CYCLES  = 2 * (WINDOW + 8);
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 225;
    localparam int PLAN_ROWS    = 25;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;
    localparam logic [FRAC_W-1:0]      FRACTION_ONE = 17'd65536;
    localparam logic [FRAC_W-1:0]      FRACTION_TOP = 17'h1FFFF;
    localparam logic [TIME_W-1:0]      TIME_TOP     = 24'hFFFFFF;

    typedef struct packed {
        logic [COUNT_W-1:0] sample_count;
        logic [TIME_W-1:0]  rank_value_b;
        logic [TIME_W-1:0]  rank_value_a;
    } percentile_beat_t;

    typedef enum logic {STEP_SAMPLE, STEP_WRITE} step_kind_e;

    typedef struct packed {
        step_kind_e             kind;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [FRAC_W-1:0]      data;
        logic [TIME_W-1:0]      frame_time;
        logic                   typed;
        percentile_beat_t       result;
    } plan_row_t;

    typedef enum logic [1:0] {STALL_NONE, STALL_HALF, STALL_RARE, STALL_HEAVY} stall_mode_e;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [FRAC_W-1:0]      cfg_data  = '0;

    // window predictor
    logic [TIME_W-1:0] ring [WINDOW];
    logic [TIME_W-1:0] ordered [WINDOW];
    int                ring_oldest = 0;
    int                ring_fill   = 0;
    logic [FRAC_W-1:0] frac_a      = RANK_FRACTION_A_RESET;
    logic [FRAC_W-1:0] frac_b      = RANK_FRACTION_B_RESET;

    percentile_beat_t pending_ranks [$];
    int               fault_count   = 0;
    int               burst_left    = 0;
    bit               hold_request  = 1'b0;
    int               hold_left     = 0;
    int               stall_left    = 0;
    stall_mode_e      stall_mode    = STALL_NONE;
    longint           cycle_count   = 0;

    plan_row_t plan [PLAN_ROWS] = '{
        '{STEP_SAMPLE, REG_RANK_FRACTION_A, 17'd0, 24'd1000, 1'b1,
          '{8'd1, 24'd1000, 24'd1000}},
        '{STEP_SAMPLE, REG_RANK_FRACTION_A, 17'd0, 24'd0, 1'b0, '0},
        '{STEP_SAMPLE, REG_RANK_FRACTION_A, 17'd0, TIME_TOP, 1'b1,
          '{8'd3, TIME_TOP, TIME_TOP}},
        '{STEP_SAMPLE, REG_RANK_FRACTION_A, 17'd0, 24'h555555, 1'b0, '0},
        '{STEP_SAMPLE, REG_RANK_FRACTION_A, 17'd0, 24'hAAAAAA, 1'b0, '0},
        '{STEP_WRITE,  REG_RANK_FRACTION_A, 17'd0, 24'd0, 1'b0, '0},
        '{STEP_WRITE,  REG_RANK_FRACTION_B, FRACTION_TOP, 24'd0, 1'b0, '0},
        '{STEP_SAMPLE, REG_RANK_FRACTION_A, 17'd0, 24'd500, 1'b1,
          '{8'd6, TIME_TOP, 24'd0}},
        '{STEP_SAMPLE, REG_RANK_FRACTION_A, 17'd0, 24'd7, 1'b0, '0},
        '{STEP_SAMPLE, REG_RANK_FRACTION_A, 17'd0, 24'd7, 1'b0, '0},
        '{STEP_SAMPLE, REG_RANK_FRACTION_A, 17'd0, 24'd7, 1'b1,
          '{8'd9, TIME_TOP, 24'd0}},
        '{STEP_WRITE,  REG_RANK_FRACTION_A, 17'd32768, 24'd0, 1'b0, '0},
        '{STEP_WRITE,  REG_RANK_FRACTION_B, 17'd1, 24'd0, 1'b0, '0},
        '{STEP_SAMPLE, REG_RANK_FRACTION_A, 17'd0, 24'd123456, 1'b0, '0},
        '{STEP_WRITE,  REG_SPARE_LO, FRACTION_TOP, 24'd0, 1'b0, '0},
        '{STEP_WRITE,  REG_SPARE_HI, 17'd0, 24'd0, 1'b0, '0},
        '{STEP_SAMPLE, REG_RANK_FRACTION_A, 17'd0, 24'd0, 1'b0, '0},
        '{STEP_WRITE,  REG_RANK_FRACTION_A, FRACTION_ONE, 24'd0, 1'b0, '0},
        '{STEP_WRITE,  REG_RANK_FRACTION_B, 17'd65535, 24'd0, 1'b0, '0},
        '{STEP_SAMPLE, REG_RANK_FRACTION_A, 17'd0, 24'd800000, 1'b1,
          '{8'd12, TIME_TOP, TIME_TOP}},
        '{STEP_SAMPLE, REG_RANK_FRACTION_A, 17'd0, 24'd1, 1'b0, '0},
        '{STEP_WRITE,  REG_RANK_FRACTION_A, RANK_FRACTION_A_RESET, 24'd0, 1'b0, '0},
        '{STEP_WRITE,  REG_RANK_FRACTION_B, RANK_FRACTION_B_RESET, 24'd0, 1'b0, '0},
        '{STEP_SAMPLE, REG_RANK_FRACTION_A, 17'd0, 24'h0F0F0F, 1'b0, '0},
        '{STEP_SAMPLE, REG_RANK_FRACTION_A, 17'd0, 24'hF0F0F0, 1'b0, '0}
    };

    sliding_window_percentile_top #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (TIME_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int rank_index(input logic [FRAC_W-1:0] frac, input int held);
        longint scaled;
        scaled = (longint'(frac) * held) >> FRAC_SHIFT;
        return (scaled > held - 1) ? held - 1 : int'(scaled);
    endfunction

    // insert into the ring, evicting the oldest once full, and keep the sorted copy in step
    function automatic percentile_beat_t advance_window(input logic [TIME_W-1:0] t);
        int                pos;
        int                held;
        logic [TIME_W-1:0] evicted;
        percentile_beat_t  beat;
        if (ring_fill < WINDOW)
        begin
            ring[(ring_oldest + ring_fill) % WINDOW] = t;
            held = ring_fill;
            ring_fill++;
        end
        else
        begin
            evicted = ring[ring_oldest];
            ring[ring_oldest] = t;
            ring_oldest = (ring_oldest + 1) % WINDOW;
            pos = 0;
            while (ordered[pos] != evicted)
                pos++;
            for (int i = pos; i < WINDOW - 1; i++)
                ordered[i] = ordered[i + 1];
            held = WINDOW - 1;
        end
        pos = held;
        while (pos > 0 && ordered[pos - 1] > t)
        begin
            ordered[pos] = ordered[pos - 1];
            pos--;
        end
        ordered[pos] = t;
        beat.rank_value_a = ordered[rank_index(frac_a, ring_fill)];
        beat.rank_value_b = ordered[rank_index(frac_b, ring_fill)];
        beat.sample_count = COUNT_W'(ring_fill);
        return beat;
    endfunction

    function automatic logic [FRAC_W-1:0] pick_fraction();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return FRACTION_ONE;
            2:       return FRACTION_TOP;
            3:       return FRAC_W'($urandom_range(0, FRACTION_ONE));
            default: return FRAC_W'($urandom);
        endcase
    endfunction

    task automatic offer_frame(input logic [TIME_W-1:0] t, input logic typed,
                               input percentile_beat_t typed_result);
        int               gap;
        percentile_beat_t want;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 5))
                0, 1, 2: gap = 0;
                3, 4:    gap = $urandom_range(1, 12);
                default: gap = $urandom_range(13, 260);
            endcase
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= t;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        want = advance_window(t);
        if (typed)
            want = typed_result;
        pending_ranks.insert(pending_ranks.size(), want);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_ranks.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] reg_index,
                                  input logic [FRAC_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (reg_index == REG_RANK_FRACTION_A)
            frac_a = data;
        else if (reg_index == REG_RANK_FRACTION_B)
            frac_b = data;
    endtask

    // result sink: scoring plus its own stall pattern and the long hold
    always @(posedge clk)
    begin : result_sink
        percentile_beat_t got;
        percentile_beat_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (pending_ranks.size() == 0)
                begin
                    $error("result beat with nothing pending: %h", m_tdata);
                    fault_count++;
                end
                else
                begin
                    want = pending_ranks.pop_front();
                    if (got.rank_value_a !== want.rank_value_a)
                    begin
                        $error("rank_value_a: expected %0d, got %0d",
                               want.rank_value_a, got.rank_value_a);
                        fault_count++;
                    end
                    if (got.rank_value_b !== want.rank_value_b)
                    begin
                        $error("rank_value_b: expected %0d, got %0d",
                               want.rank_value_b, got.rank_value_b);
                        fault_count++;
                    end
                    if (got.sample_count !== want.sample_count)
                    begin
                        $error("sample_count: expected %0d, got %0d",
                               want.sample_count, got.sample_count);
                        fault_count++;
                    end
                end
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (stall_left == 0)
                begin
                    stall_mode = stall_mode_e'($urandom_range(0, 3));
                    stall_left = $urandom_range(8, 200);
                end
                stall_left--;
                case (stall_mode)
                    STALL_NONE:  m_tready <= 1'b1;
                    STALL_HALF:  m_tready <= 1'($urandom_range(0, 1));
                    STALL_RARE:  m_tready <= ($urandom_range(0, 7) != 0);
                    STALL_HEAVY: m_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        logic [TIME_W-1:0] frame;
        frame = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < PLAN_ROWS; r++)
        begin
            if (plan[r].kind == STEP_WRITE)
            begin
                drain_results();
                write_register(plan[r].reg_index, plan[r].data);
                if (r == PLAN_ROWS - 1 || plan[r + 1].kind != STEP_WRITE)
                    cfg_valid <= 1'b0;
            end
            else
                offer_frame(plan[r].frame_time, plan[r].typed, plan[r].result);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_results();
            write_register(REG_RANK_FRACTION_A, pick_fraction());
            write_register(REG_RANK_FRACTION_B, pick_fraction());
            if ($urandom_range(0, 2) == 0)
                write_register(phase[0] ? REG_SPARE_HI : REG_SPARE_LO, FRAC_W'($urandom));
            cfg_valid <= 1'b0;
            if (phase == 2 || phase == 5)
                hold_request = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                case ($urandom_range(0, 7))
                    0, 1, 2, 3: frame = TIME_W'($urandom);
                    4:          frame = TIME_W'($urandom_range(0, 15));
                    5:          frame = TIME_TOP - TIME_W'($urandom_range(0, 15));
                    6:          frame = frame + TIME_W'($urandom_range(0, 300));
                    default:    frame = frame;
                endcase
                offer_frame(frame, 1'b0, '0);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fault_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
